// File: design/jpnp_pkg.sv
// ----------------------------------------------------------------------------
// jpnp_pkg
// Shared constants and the direction table of the neighbour pruner.
// ----------------------------------------------------------------------------
package jpnp_pkg;

  localparam int COORD_W      = 6;
  localparam int CFG_W        = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int DEF_MAX_SIDE = 64;
  localparam int NUM_DIRS     = 8;
  localparam int SLOT_W       = 3;

  localparam logic [CFG_W-1:0] CFG_RESET_SIDE = CFG_W'(64);

  // operation codes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  typedef logic signed [1:0] off_t;

  // E, W, N, S, SE, SW, NE, NW with y growing southwards
  localparam off_t DIR_DX [NUM_DIRS] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                         2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam off_t DIR_DY [NUM_DIRS] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1,
                                         2'sd1, 2'sd1, -2'sd1, -2'sd1};

endpackage

// File: design/jump_point_neighbour_pruner_top.sv
// ----------------------------------------------------------------------------
// jump_point_neighbour_pruner_top
// Wall map with jump-point neighbour pruning for grid path search.
// ----------------------------------------------------------------------------
// The wall map sits in one RAM with one row of the grid per entry. After reset
// the block runs a clearing pass over min(MAX_SIDE, 64) rows (one row a cycle)
// with in_stall high; configuration writes are taken during it. A cell write
// goes through accept, row read and row write back. A query goes through the
// accept, a fetch of the three rows around the current cell through the
// single RAM read port and an evaluation of the 3x3 window, then gives one
// result word per cycle while the output is not stalled. The last result word
// sits in the output register while the next input word is accepted.
module jump_point_neighbour_pruner_top #(
  parameter int MAX_SIDE = jpnp_pkg::DEF_MAX_SIDE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [jpnp_pkg::COORD_W-1:0] in_cell_x,
  input  logic [jpnp_pkg::COORD_W-1:0] in_cell_y,
  input  logic                         in_wall,
  input  logic                         in_has_parent,
  input  logic [jpnp_pkg::COORD_W-1:0] in_parent_x,
  input  logic [jpnp_pkg::COORD_W-1:0] in_parent_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [jpnp_pkg::COORD_W-1:0] out_neighbour_x,
  output logic [jpnp_pkg::COORD_W-1:0] out_neighbour_y,
  output logic                         out_found,
  output logic                         out_last,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [jpnp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jpnp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW         = jpnp_pkg::COORD_W;
  localparam int FULL_SIDE  = 2 ** CW;
  localparam int STORE_SIDE = (MAX_SIDE < FULL_SIDE) ? MAX_SIDE : FULL_SIDE;
  localparam int ROW_AW     = $clog2(STORE_SIDE);
  localparam int SW         = CW + 2;   // signed coordinate, one cell beyond the square

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WR_RD  = 3'd2;
  localparam logic [2:0] ST_WR_WB  = 3'd3;
  localparam logic [2:0] ST_Q_RD   = 3'd4;
  localparam logic [2:0] ST_Q_EVAL = 3'd5;
  localparam logic [2:0] ST_Q_EMIT = 3'd6;

  localparam logic [1:0] LAST_STEP = 2'd3;

  typedef logic signed [SW-1:0] scoord_t;

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  logic [2:0]                   state_r, state_nxt;
  logic [ROW_AW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [1:0]                   step_r, step_nxt;
  logic                         rd_row_ok_r, rd_row_ok_nxt;
  logic [CW-1:0]                cx_r, cx_nxt;
  logic [CW-1:0]                cy_r, cy_nxt;
  logic                         wall_r, wall_nxt;
  logic                         has_par_r, has_par_nxt;
  jpnp_pkg::off_t               dx_r, dx_nxt;
  jpnp_pkg::off_t               dy_r, dy_nxt;
  logic [8:0]                   win_pass_r, win_pass_nxt;
  logic [jpnp_pkg::NUM_DIRS-1:0] mask_r, mask_nxt;
  logic [jpnp_pkg::CFG_W-1:0]   grid_w_r, grid_w_nxt;
  logic [jpnp_pkg::CFG_W-1:0]   grid_h_r, grid_h_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [CW-1:0]                out_x_r, out_x_nxt;
  logic [CW-1:0]                out_y_r, out_y_nxt;
  logic                         out_found_r, out_found_nxt;
  logic                         out_last_r, out_last_nxt;

  // RAM ports
  logic                    ram_wr_en;
  logic [ROW_AW-1:0]       ram_wr_addr;
  logic [STORE_SIDE-1:0]   ram_wr_data;
  logic                    ram_rd_en;
  logic [ROW_AW-1:0]       ram_rd_addr;
  logic [STORE_SIDE-1:0]   ram_rd_data;

  jpnp_ram #(
    .DATA_W (STORE_SIDE),
    .DEPTH  (STORE_SIDE),
    .ADDR_W (ROW_AW)
  ) u_wall_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // -------------------------------------------------------------------------
  // helpers
  // -------------------------------------------------------------------------
  function automatic jpnp_pkg::off_t sgn_diff(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
    jpnp_pkg::off_t r;
    if (a > b) begin
      r = 2'sd1;
    end else if (a < b) begin
      r = -2'sd1;
    end else begin
      r = 2'sd0;
    end
    return r;
  endfunction

  function automatic logic [3:0] win_idx(input jpnp_pkg::off_t ox,
                                         input jpnp_pkg::off_t oy);
    return 4'((int'(oy) + 1) * 3 + int'(ox) + 1);
  endfunction

  // move from the current cell by one window offset
  function automatic logic move_ok(input logic [8:0]     pass,
                                   input logic [8:0]     inb,
                                   input jpnp_pkg::off_t ox,
                                   input jpnp_pkg::off_t oy);
    logic ok;
    ok = inb[win_idx(ox, oy)] && pass[win_idx(ox, oy)];
    if (ox != 2'sd0 && oy != 2'sd0) begin
      ok = ok && (pass[win_idx(ox, 2'sd0)] || pass[win_idx(2'sd0, oy)]);
    end
    return ok;
  endfunction

  // -------------------------------------------------------------------------
  // window around the current cell
  // -------------------------------------------------------------------------
  scoord_t  win_x [3];
  scoord_t  win_y [3];
  logic [2:0] col_ok;
  logic [8:0] win_inb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_x[i]  = $signed({2'b00, cx_r}) + scoord_t'(i - 1);
      win_y[i]  = $signed({2'b00, cy_r}) + scoord_t'(i - 1);
      col_ok[i] = (win_x[i] >= 0) && (int'(win_x[i]) < STORE_SIDE);
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        win_inb[j*3+i] = (win_x[i] >= 0) && (win_y[j] >= 0) &&
                         (win_x[i] < $signed({1'b0, grid_w_r})) &&
                         (win_y[j] < $signed({1'b0, grid_h_r})) &&
                         (int'(win_x[i]) < MAX_SIDE) && (int'(win_y[j]) < MAX_SIDE);
      end
    end
  end

  // -------------------------------------------------------------------------
  // candidate slots in emission order
  // -------------------------------------------------------------------------
  jpnp_pkg::off_t slot_ox [jpnp_pkg::NUM_DIRS];
  jpnp_pkg::off_t slot_oy [jpnp_pkg::NUM_DIRS];
  logic [jpnp_pkg::NUM_DIRS-1:0] slot_ok;
  jpnp_pkg::off_t ix, iy;

  always_comb begin
    ix = dy_r;
    iy = dx_r;
    for (int k = 0; k < jpnp_pkg::NUM_DIRS; k++) begin
      slot_ox[k] = 2'sd0;
      slot_oy[k] = 2'sd0;
      slot_ok[k] = 1'b0;
    end
    if (!has_par_r) begin
      for (int k = 0; k < jpnp_pkg::NUM_DIRS; k++) begin
        slot_ox[k] = jpnp_pkg::DIR_DX[k];
        slot_oy[k] = jpnp_pkg::DIR_DY[k];
        slot_ok[k] = move_ok(win_pass_r, win_inb, slot_ox[k], slot_oy[k]);
      end
    end else if (dx_r != 2'sd0 && dy_r != 2'sd0) begin
      slot_ox[0] = dx_r;
      slot_oy[0] = dy_r;
      slot_ok[0] = move_ok(win_pass_r, win_inb, dx_r, dy_r);
      slot_ox[1] = dx_r;
      slot_ok[1] = move_ok(win_pass_r, win_inb, dx_r, 2'sd0);
      slot_oy[2] = dy_r;
      slot_ok[2] = move_ok(win_pass_r, win_inb, 2'sd0, dy_r);
      // forced neighbours seen from the cell behind; the two-cell step from
      // there is straight, so only its target cell counts
      slot_ox[3] = dx_r;
      slot_oy[3] = -dy_r;
      slot_ok[3] = !move_ok(win_pass_r, win_inb, 2'sd0, -dy_r) &&
                   win_inb[win_idx(slot_ox[3], slot_oy[3])] &&
                   win_pass_r[win_idx(slot_ox[3], slot_oy[3])];
      slot_ox[4] = -dx_r;
      slot_oy[4] = dy_r;
      slot_ok[4] = !move_ok(win_pass_r, win_inb, -dx_r, 2'sd0) &&
                   win_inb[win_idx(slot_ox[4], slot_oy[4])] &&
                   win_pass_r[win_idx(slot_ox[4], slot_oy[4])];
    end else begin
      slot_ox[0] = dx_r;
      slot_oy[0] = dy_r;
      slot_ok[0] = move_ok(win_pass_r, win_inb, dx_r, dy_r);
      slot_ox[1] = 2'(ix + dx_r);
      slot_oy[1] = 2'(iy + dy_r);
      slot_ok[1] = !move_ok(win_pass_r, win_inb, ix, iy) &&
                   move_ok(win_pass_r, win_inb, slot_ox[1], slot_oy[1]);
      slot_ox[2] = 2'(dx_r - ix);
      slot_oy[2] = 2'(dy_r - iy);
      slot_ok[2] = !move_ok(win_pass_r, win_inb, -ix, -iy) &&
                   move_ok(win_pass_r, win_inb, slot_ox[2], slot_oy[2]);
    end
  end

  // lowest pending slot
  logic [jpnp_pkg::SLOT_W-1:0]   pick;
  logic [jpnp_pkg::NUM_DIRS-1:0] mask_rest;

  always_comb begin
    pick = '0;
    for (int k = jpnp_pkg::NUM_DIRS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        pick = jpnp_pkg::SLOT_W'(k);
      end
    end
    mask_rest = mask_r & ~(jpnp_pkg::NUM_DIRS'(1) << pick);
  end

  // -------------------------------------------------------------------------
  // control
  // -------------------------------------------------------------------------
  logic    in_acc;
  logic    out_free;
  scoord_t rd_y;
  logic    rd_row_ok;
  logic [1:0] cap_row;
  logic [STORE_SIDE-1:0] bit_mask;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    step_nxt      = step_r;
    rd_row_ok_nxt = rd_row_ok_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    wall_nxt      = wall_r;
    has_par_nxt   = has_par_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    win_pass_nxt  = win_pass_r;
    mask_nxt      = mask_r;
    grid_w_nxt    = grid_w_r;
    grid_h_nxt    = grid_h_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = cy_r[ROW_AW-1:0];
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = cy_r[ROW_AW-1:0];

    rd_y      = $signed({2'b00, cy_r}) + $signed({{(SW-2){1'b0}}, step_r}) - scoord_t'(1);
    rd_row_ok = (rd_y >= 0) && (int'(rd_y) < STORE_SIDE);
    cap_row   = step_r - 2'd1;
    bit_mask  = STORE_SIDE'(1) << cx_r[ROW_AW-1:0];

    if (cfg_wr_en) begin
      if (cfg_index == jpnp_pkg::CFG_GRID_WIDTH) begin
        grid_w_nxt = cfg_data;
      end else begin
        grid_h_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + ROW_AW'(1);
        if (clr_cnt_r == ROW_AW'(STORE_SIDE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cx_nxt      = in_cell_x;
          cy_nxt      = in_cell_y;
          wall_nxt    = in_wall;
          has_par_nxt = in_has_parent;
          dx_nxt      = sgn_diff(in_cell_x, in_parent_x);
          dy_nxt      = sgn_diff(in_cell_y, in_parent_y);
          step_nxt    = '0;
          if (in_operation == jpnp_pkg::OP_QUERY) begin
            state_nxt = ST_Q_RD;
          end else if ((int'(in_cell_x) < STORE_SIDE) &&
                       (int'(in_cell_y) < STORE_SIDE)) begin
            state_nxt = ST_WR_RD;
          end
        end
      end
      ST_WR_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_WR_WB;
      end
      ST_WR_WB: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = wall_r ? (ram_rd_data | bit_mask) : (ram_rd_data & ~bit_mask);
        state_nxt   = ST_IDLE;
      end
      ST_Q_RD: begin
        // issue row cy-1+step, capture the row read in the previous step
        if (step_r != LAST_STEP) begin
          ram_rd_en     = rd_row_ok;
          ram_rd_addr   = rd_y[ROW_AW-1:0];
          rd_row_ok_nxt = rd_row_ok;
        end
        if (step_r != 2'd0) begin
          for (int i = 0; i < 3; i++) begin
            win_pass_nxt[int'(cap_row)*3+i] =
              !(rd_row_ok_r && col_ok[i] && ram_rd_data[win_x[i][ROW_AW-1:0]]);
          end
        end
        step_nxt = step_r + 2'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_Q_EVAL;
        end
      end
      ST_Q_EVAL: begin
        mask_nxt  = slot_ok;
        state_nxt = ST_Q_EMIT;
      end
      ST_Q_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (mask_r == '0) begin
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_found_nxt = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            out_x_nxt     = CW'(cx_r + {{(CW-2){slot_ox[pick][1]}}, slot_ox[pick]});
            out_y_nxt     = CW'(cy_r + {{(CW-2){slot_oy[pick][1]}}, slot_oy[pick]});
            out_found_nxt = 1'b1;
            out_last_nxt  = (mask_rest == '0);
            mask_nxt      = mask_rest;
            if (mask_rest == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      rd_row_ok_r <= 1'b0;
      mask_r      <= '0;
      grid_w_r    <= jpnp_pkg::CFG_RESET_SIDE;
      grid_h_r    <= jpnp_pkg::CFG_RESET_SIDE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      step_r      <= step_nxt;
      rd_row_ok_r <= rd_row_ok_nxt;
      mask_r      <= mask_nxt;
      grid_w_r    <= grid_w_nxt;
      grid_h_r    <= grid_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    wall_r      <= wall_nxt;
    has_par_r   <= has_par_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    win_pass_r  <= win_pass_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_neighbour_x = out_x_r;
  assign out_neighbour_y = out_y_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

endmodule

// File: design/jpnp_ram.sv
// ----------------------------------------------------------------------------
// jpnp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jpnp_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/jpnp_checker.sv
// ----------------------------------------------------------------------------
// jpnp_checker
// Port-level checks of the neighbour pruner, bound to the top level.
// ----------------------------------------------------------------------------
module jpnp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_operation,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [jpnp_pkg::COORD_W-1:0]   out_neighbour_x,
  input logic [jpnp_pkg::COORD_W-1:0]   out_neighbour_y,
  input logic                           out_found,
  input logic                           out_last
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_neighbour_x, out_neighbour_y, out_found, out_last}))
    else $error("stalled result word changed");

  // an empty answer is a single closing word at the origin
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_neighbour_x == '0 &&
      out_neighbour_y == '0)
    else $error("empty answer word malformed");

  // a cell write gives no result word
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == jpnp_pkg::OP_WRITE && (!out_valid || !out_stall)
      |=> !out_valid)
    else $error("result word after a cell write");

  // one query at a time
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == jpnp_pkg::OP_QUERY |=> in_stall)
    else $error("input taken right after a query");

endmodule

bind jump_point_neighbour_pruner_top jpnp_checker u_jpnp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_neighbour_x (out_neighbour_x),
  .out_neighbour_y (out_neighbour_y),
  .out_found       (out_found),
  .out_last        (out_last)
);

// File: tb/jump_point_neighbour_pruner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jump_point_neighbour_pruner_top_tb
// Self-checking bench for the wall map and jump-point neighbour pruner.
// A short table of directed words covers grid corners, forced neighbours,
// corner cutting, a parent on the current cell and zero, one and oversized
// grid registers. Random phases follow, one per grid setting. Each phase
// centers its writes and queries on a small patch of the grid, so walls pile
// up and forced neighbours show up. A local model of the pruner predicts
// every result word but for table rows whose answers are typed in. Sender
// gaps and receiver stalls change every two phases.
// ----------------------------------------------------------------------------
module jump_point_neighbour_pruner_top_tb;
  import jpnp_pkg::*;

  localparam int SIDE          = 64;
  localparam int SPAN          = 4;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_WORDS   = 19;
  localparam int NUM_PHASES    = 6;

  // E, W, N, S, then the diagonals; y grows southwards
  localparam int STEP_DX [8] = '{1, -1, 0, 0, 1, -1, 1, -1};
  localparam int STEP_DY [8] = '{0, 0, -1, 1, 1, 1, -1, -1};

  localparam int PHASE_W [NUM_PHASES] = '{64, 8, 127, 1, 20, 64};
  localparam int PHASE_H [NUM_PHASES] = '{64, 8, 6, 64, 127, 3};

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               wall;
    logic               has_parent;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } grid_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic               found;
    logic               last;
  } nbr_t;

  typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    grid_word_t           w;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [1:0]           n_typed;
  } stim_row_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_operation  = OP_WRITE;
  logic [COORD_W-1:0]   in_cell_x     = '0;
  logic [COORD_W-1:0]   in_cell_y     = '0;
  logic                 in_wall       = 1'b0;
  logic                 in_has_parent = 1'b0;
  logic [COORD_W-1:0]   in_parent_x   = '0;
  logic [COORD_W-1:0]   in_parent_y   = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [COORD_W-1:0]   out_neighbour_x;
  logic [COORD_W-1:0]   out_neighbour_y;
  logic                 out_found;
  logic                 out_last;
  logic                 cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_data      = '0;

  // model state
  bit               wall_bits [SIDE*SIDE];
  logic [CFG_W-1:0] width_reg  = CFG_RESET_SIDE;
  logic [CFG_W-1:0] height_reg = CFG_RESET_SIDE;

  nbr_t       expected_nbrs [$];
  nbr_t       hits [$];
  stim_row_t  stim_rows [$];
  nbr_t       typed_nbrs [$];

  int          send_idle_pct = 29;
  int          stall_pct     = 73;
  int          focus_x;
  int          focus_y;
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;

  jump_point_neighbour_pruner_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_wall         (in_wall),
    .in_has_parent   (in_has_parent),
    .in_parent_x     (in_parent_x),
    .in_parent_y     (in_parent_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_neighbour_x (out_neighbour_x),
    .out_neighbour_y (out_neighbour_y),
    .out_found       (out_found),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("jump_point_neighbour_pruner_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // neighbour prediction
  // --------------------------------------------------------------------------
  function automatic int clip_side(logic [CFG_W-1:0] side_reg);
    return (side_reg > SIDE) ? SIDE : int'(side_reg);
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < clip_side(width_reg) && y < clip_side(height_reg);
  endfunction

  // anything outside the stored square reads as open floor
  function automatic bit is_open(int x, int y);
    if (x < 0 || y < 0 || x >= SIDE || y >= SIDE) return 1'b1;
    return !wall_bits[y*SIDE + x];
  endfunction

  function automatic bit can_step(int x, int y, int dx, int dy);
    if (!on_grid(x + dx, y + dy) || !is_open(x + dx, y + dy)) return 1'b0;
    // no squeezing between two walls on a diagonal
    if (dx != 0 && dy != 0) return is_open(x + dx, y) || is_open(x, y + dy);
    return 1'b1;
  endfunction

  function automatic void add_hit(int x, int y);
    nbr_t n;
    if (hits.size() >= 8) return;
    n.nx    = COORD_W'(x);
    n.ny    = COORD_W'(y);
    n.found = 1'b1;
    n.last  = 1'b0;
    hits.insert(hits.size(), n);
  endfunction

  function automatic void try_step(int x, int y, int dx, int dy);
    if (can_step(x, y, dx, dy)) add_hit(x + dx, y + dy);
  endfunction

  function automatic int sign_of(int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic void prune_neighbours(grid_word_t w);
    int   cx, cy, dx, dy, bx, by, ix, iy, i;
    nbr_t none;
    cx = int'(w.cx);
    cy = int'(w.cy);
    if (w.op == OP_WRITE) begin
      wall_bits[cy*SIDE + cx] = w.wall;
      return;
    end
    hits.delete();
    if (!w.has_parent) begin
      for (i = 0; i < 8; i++) try_step(cx, cy, STEP_DX[i], STEP_DY[i]);
    end else begin
      dx = sign_of(cx - int'(w.px));
      dy = sign_of(cy - int'(w.py));
      if (dx != 0 && dy != 0) begin
        bx = cx - dx;
        by = cy - dy;
        try_step(cx, cy, dx, dy);
        try_step(cx, cy, dx, 0);
        try_step(cx, cy, 0, dy);
        if (!can_step(bx, by, dx, 0) && can_step(bx, by, 2*dx, 0)) add_hit(bx + 2*dx, by);
        if (!can_step(bx, by, 0, dy) && can_step(bx, by, 0, 2*dy)) add_hit(bx, by + 2*dy);
      end else begin
        ix = dy;
        iy = dx;
        try_step(cx, cy, dx, dy);
        if (!can_step(cx, cy, ix, iy) && can_step(cx, cy, ix + dx, iy + dy))
          add_hit(cx + ix + dx, cy + iy + dy);
        if (!can_step(cx, cy, -ix, -iy) && can_step(cx, cy, dx - ix, dy - iy))
          add_hit(cx - ix + dx, cy - iy + dy);
      end
    end
    if (hits.size() == 0) begin
      none      = '0;
      none.last = 1'b1;
      expected_nbrs.insert(expected_nbrs.size(), none);
    end else begin
      hits[hits.size()-1].last = 1'b1;
      foreach (hits[k]) expected_nbrs.insert(expected_nbrs.size(), hits[k]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    nbr_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_nbrs.size() == 0) begin
        $error("unexpected result word: x=%0d y=%0d found=%0d last=%0d",
               out_neighbour_x, out_neighbour_y, out_found, out_last);
        fail_count++;
      end else begin
        want = expected_nbrs.pop_front();
        check_field("neighbour_x", want.nx, out_neighbour_x);
        check_field("neighbour_y", want.ny, out_neighbour_y);
        check_field("found", want.found, out_found);
        check_field("last", want.last, out_last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_word(grid_word_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= w.op;
    in_cell_x     <= w.cx;
    in_cell_y     <= w.cy;
    in_wall       <= w.wall;
    in_has_parent <= w.has_parent;
    in_parent_x   <= w.px;
    in_parent_y   <= w.py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain all results, then give a trailing cell write time to land
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_nbrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic void add_write(int x, int y, bit wall);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_WORD;
    row.w.op    = OP_WRITE;
    row.w.cx    = COORD_W'(x);
    row.w.cy    = COORD_W'(y);
    row.w.wall  = wall;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // wall is set on queries to show it is ignored there
  function automatic void add_query(int x, int y, bit hp, int px, int py, int n_typed);
    stim_row_t row;
    row              = '0;
    row.kind         = ROW_WORD;
    row.w.op         = OP_QUERY;
    row.w.cx         = COORD_W'(x);
    row.w.cy         = COORD_W'(y);
    row.w.wall       = 1'b1;
    row.w.has_parent = hp;
    row.w.px         = COORD_W'(px);
    row.w.py         = COORD_W'(py);
    row.n_typed      = 2'(n_typed);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic void add_typed(int x, int y, bit found, bit last);
    nbr_t n;
    n.nx    = COORD_W'(x);
    n.ny    = COORD_W'(y);
    n.found = found;
    n.last  = last;
    typed_nbrs.insert(typed_nbrs.size(), n);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = CFG_W'(val);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  task automatic run_table();
    stim_row_t row;
    bit        drained;
    drained = 1'b1;
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_REG) begin
        if (!drained) settle_block();
        drained = 1'b1;
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        drained = 1'b0;
        push_word(row.w);
        if (row.n_typed == 0) prune_neighbours(row.w);
        else repeat (row.n_typed)
          expected_nbrs.insert(expected_nbrs.size(), typed_nbrs.pop_front());
      end
    end
  endtask

  function automatic int pick_focus(logic [CFG_W-1:0] side_reg);
    int used;
    used = clip_side(side_reg);
    if (used <= SPAN) return 0;
    case ($urandom_range(0, 2))
      0: return 0;
      1: return used - SPAN;
      default: return int'($urandom_range(0, used - SPAN));
    endcase
  endfunction

  // mostly writes and short-hop queries on a small patch, some pure noise
  function automatic grid_word_t random_word();
    grid_word_t w;
    int         pick, dx, dy, reach;
    pick         = int'($urandom_range(0, 99));
    w.op         = OP_QUERY;
    w.cx         = COORD_W'($urandom);
    w.cy         = COORD_W'($urandom);
    w.wall       = 1'($urandom);
    w.has_parent = 1'($urandom);
    w.px         = COORD_W'($urandom);
    w.py         = COORD_W'($urandom);
    if (pick < 10) begin
      w.op = 1'($urandom);
      return w;
    end
    w.cx = COORD_W'(focus_x + int'($urandom_range(0, SPAN - 1)));
    w.cy = COORD_W'(focus_y + int'($urandom_range(0, SPAN - 1)));
    if (pick < 50) begin
      w.op   = OP_WRITE;
      w.wall = ($urandom_range(0, 99) < 60);
    end else if (pick < 92) begin
      w.has_parent = 1'b1;
      dx           = int'($urandom_range(0, 2)) - 1;
      dy           = int'($urandom_range(0, 2)) - 1;
      reach        = int'($urandom_range(1, 3));
      w.px         = COORD_W'(int'(w.cx) - dx*reach);
      w.py         = COORD_W'(int'(w.cy) - dy*reach);
    end else begin
      w.has_parent = 1'b0;
    end
    return w;
  endfunction

  task automatic run_phase(int w_val, int h_val);
    grid_word_t w;
    settle_block();
    write_reg(CFG_GRID_WIDTH, CFG_W'(w_val));
    write_reg(CFG_GRID_HEIGHT, CFG_W'(h_val));
    focus_x = pick_focus(width_reg);
    focus_y = pick_focus(height_reg);
    repeat (PHASE_WORDS) begin
      w = random_word();
      push_word(w);
      prune_neighbours(w);
    end
  endtask

  initial begin
    // open corners on an empty map
    add_query(0, 0, 0, 63, 63, 3);
    add_typed(1, 0, 1, 0);
    add_typed(0, 1, 1, 0);
    add_typed(1, 1, 1, 1);
    add_query(63, 63, 0, 0, 0, 3);
    add_typed(62, 63, 1, 0);
    add_typed(63, 62, 1, 0);
    add_typed(62, 62, 1, 1);
    // walls north and west of (5,5), plus the far corner
    add_write(5, 4, 1);
    add_write(4, 5, 1);
    add_write(63, 63, 1);
    add_query(5, 5, 1, 4, 5, 0);
    add_query(5, 5, 1, 5, 6, 0);
    add_query(4, 4, 1, 3, 5, 0);
    add_query(4, 4, 1, 3, 3, 0);
    add_query(62, 62, 0, 0, 0, 0);
    add_query(7, 7, 1, 7, 7, 0);
    add_query(0, 0, 1, 63, 63, 0);
    add_query(63, 0, 1, 0, 63, 0);
    add_write(5, 4, 0);
    // no columns at all
    add_reg(CFG_GRID_WIDTH, 0);
    add_query(0, 0, 0, 0, 0, 1);
    add_typed(0, 0, 0, 1);
    add_reg(CFG_GRID_WIDTH, 127);
    add_reg(CFG_GRID_HEIGHT, 1);
    add_query(3, 0, 0, 0, 0, 0);
    add_query(10, 5, 1, 9, 5, 0);
    // single cell grid
    add_reg(CFG_GRID_WIDTH, 1);
    add_query(0, 0, 0, 0, 0, 1);
    add_typed(0, 0, 0, 1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_table();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 29;
          stall_pct     = 73;
        end
        1: begin
          send_idle_pct = 73;
          stall_pct     = 29;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      run_phase(PHASE_W[p], PHASE_H[p]);
    end
    settle_block();

    if (fail_count == 0) begin
      $display("jump_point_neighbour_pruner_top test passed");
    end else begin
      $display("jump_point_neighbour_pruner_top test failed");
    end
    $finish;
  end

endmodule

// File: jump_point_neighbour_pruner_top.f
design/jpnp_pkg.sv
design/jpnp_ram.sv
design/jump_point_neighbour_pruner_top.sv
design/jpnp_checker.sv
tb/jump_point_neighbour_pruner_top_tb.sv
